FILE: rtl/zmsr_pkg.sv
// shared types, constants and crc functions for the zmodem data subpacket receiver
package zmsr_pkg;

  localparam int BufDepthDef = 1024;

  localparam int SymW    = 9;
  localparam int LenW    = 11;
  localparam int IdxW    = 10;
  localparam int PosW    = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  localparam logic [LenW-1:0] MaxLenReset = 11'd1024;
  localparam logic [31:0]     CrcInit32   = 32'hffff_ffff;

  localparam logic [7:0] TypeE = 8'h68;
  localparam logic [7:0] TypeG = 8'h69;
  localparam logic [7:0] TypeQ = 8'h6a;
  localparam logic [7:0] TypeW = 8'h6b;

  typedef enum logic [2:0] {
    ST_CONT     = 3'd0,
    ST_END      = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_BAD_TYPE = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CRC32_MODE    = 2'd0,
    CFG_MAX_LEN       = 2'd1,
    CFG_ACK_ENABLE    = 2'd2,
    CFG_FILE_POS_INIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            timed_out;
  } sym_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [IdxW-1:0]   byte_index;
    status_e           status;
    logic              send_ack;
    logic              send_nak;
    logic [PosW-1:0]   ack_position;
    logic [LenW-1:0]   frame_length;
  } res_t;

  typedef struct packed {
    logic              en;
    cfg_idx_e          index;
    logic [CfgW-1:0]   data;
  } cfg_wr_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hedb8_8320) : (c >> 1);
    end
    return c;
  endfunction

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/zmsr_if.sv
// handshake channel interfaces: symbol input, result output, config write
interface zmsr_sym_if;
  logic                        valid;
  logic                        ready;
  logic [zmsr_pkg::SymW-1:0]   symbol;
  logic                        timed_out;

  modport source (output valid, output symbol, output timed_out, input ready);
  modport sink   (input valid, input symbol, input timed_out, output ready);
endinterface

interface zmsr_res_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [7:0]                  data_byte;
  logic [zmsr_pkg::IdxW-1:0]   byte_index;
  logic [2:0]                  status;
  logic                        send_ack;
  logic                        send_nak;
  logic [zmsr_pkg::PosW-1:0]   ack_position;
  logic [zmsr_pkg::LenW-1:0]   frame_length;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output send_ack, output send_nak,
                  output ack_position, output frame_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input status, input send_ack, input send_nak,
                  input ack_position, input frame_length, output ready);
endinterface

interface zmsr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [zmsr_pkg::CfgIdxW-1:0]  index;
  logic [zmsr_pkg::CfgW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/zmodem_data_subpacket_receiver_unit.sv
// zmodem data subpacket receiver: crc-16/crc-32 check and status per subpacket
// symbol words wait in the input register; result words wait in the result register
// throughput: one symbol word per cycle while no result word is stalled, set by the
//   single-byte crc fold between the input register and the result register
// reset: async active low; crc-16 mode, length limit 1024, ack enabled, position 0
// config writes are taken every cycle; a position write overrides a same-cycle update
module zmodem_data_subpacket_receiver_unit #(
  parameter int BUF_DEPTH = zmsr_pkg::BufDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  zmsr_sym_if.sink    sym_i,
  zmsr_res_if.source  res_o,
  zmsr_cfg_if.sink    cfg_i
);
  import zmsr_pkg::*;

  sym_t    sym_in;
  sym_t    sym_held;
  logic    held_valid;
  logic    take;
  cfg_wr_t cfg_wr;
  res_t    res;

  assign sym_in.symbol    = sym_i.symbol;
  assign sym_in.timed_out = sym_i.timed_out;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.en    = cfg_i.valid;
  assign cfg_wr.index = cfg_idx_e'(cfg_i.index);
  assign cfg_wr.data  = cfg_i.data;

  zmsr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sym_i.valid),
    .ready_o (sym_i.ready),
    .sym_i   (sym_in),
    .valid_o (held_valid),
    .sym_o   (sym_held),
    .take_i  (take)
  );

  zmsr_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .sym_i       (sym_held),
    .take_o      (take),
    .cfg_i       (cfg_wr),
    .res_valid_o (res_o.valid),
    .res_o       (res),
    .res_ready_i (res_o.ready)
  );

  assign res_o.kind         = res.kind;
  assign res_o.data_byte    = res.data_byte;
  assign res_o.byte_index   = res.byte_index;
  assign res_o.status       = res.status;
  assign res_o.send_ack     = res.send_ack;
  assign res_o.send_nak     = res.send_nak;
  assign res_o.ack_position = res.ack_position;
  assign res_o.frame_length = res.frame_length;

endmodule

FILE: rtl/zmsr_in_stage.sv
// input register for incoming symbol words
module zmsr_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  zmsr_pkg::sym_t   sym_i,
  output logic             valid_o,
  output zmsr_pkg::sym_t   sym_o,
  input  logic             take_i
);
  import zmsr_pkg::*;

  logic valid_q;
  sym_t sym_q;

  // refill in the same cycle the core consumes the held word
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign sym_o   = sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sym_q <= sym_i;
    end
  end

endmodule

FILE: rtl/zmsr_core.sv
// subpacket state, crc update, config registers and result register
module zmsr_core #(
  parameter int BUF_DEPTH = zmsr_pkg::BufDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  zmsr_pkg::sym_t     sym_i,
  output logic               take_o,
  input  zmsr_pkg::cfg_wr_t  cfg_i,
  output logic               res_valid_o,
  output zmsr_pkg::res_t     res_o,
  input  logic               res_ready_i
);
  import zmsr_pkg::*;

  localparam logic [LenW-1:0] LimCap =
    LenW'((BUF_DEPTH > (2**LenW - 1)) ? (2**LenW - 1) : BUF_DEPTH);

  typedef enum logic {
    PH_PAYLOAD = 1'b0,
    PH_TRAILER = 1'b1
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            mode32_q, mode32_d;
  logic [31:0]     crc_q, crc_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [31:0]     trl_q, trl_d;
  logic [1:0]      got_q, got_d;
  logic            bad_q, bad_d;
  logic [7:0]      type_q, type_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            fresh_q, fresh_d;

  logic            crc32_mode_q;
  logic [LenW-1:0] max_len_q;
  logic            ack_en_q;

  logic            res_valid_q;
  res_t            res_q;
  res_t            res_d;
  logic            has_res;

  logic            adv;
  logic            mode;
  logic [31:0]     crc_cur;
  logic [31:0]     crc_fold;
  logic [31:0]     expect_crc;
  logic [7:0]      byte_v;
  logic            term;
  logic [LenW-1:0] limit;
  logic            done;
  logic            restart;

  assign adv    = valid_i && (!res_valid_q || res_ready_i);
  assign take_o = adv;

  always_comb begin
    // first word of a subpacket samples the crc mode
    mode     = fresh_q ? crc32_mode_q : mode32_q;
    crc_cur  = fresh_q ? (crc32_mode_q ? CrcInit32 : 32'h0) : crc_q;
    byte_v   = sym_i.symbol[7:0];
    term     = sym_i.symbol[8];
    limit    = (max_len_q < LimCap) ? max_len_q : LimCap;
    crc_fold = mode ? crc32_fold(crc_cur, byte_v)
                    : {16'h0, crc16_fold(crc_cur[15:0], byte_v)};
    expect_crc = mode ? ~crc_cur : {16'h0, crc_cur[15:0]};
    done     = mode ? (got_q == 2'd3) : (got_q == 2'd1);

    phase_d  = phase_q;
    mode32_d = mode;
    crc_d    = crc_cur;
    cnt_d    = cnt_q;
    trl_d    = trl_q;
    got_d    = got_q;
    bad_d    = bad_q;
    type_d   = type_q;
    pos_d    = pos_q;
    fresh_d  = 1'b0;
    has_res  = 1'b0;
    res_d    = '0;
    restart  = 1'b0;

    if (sym_i.timed_out) begin
      has_res            = 1'b1;
      res_d.kind         = 1'b1;
      res_d.status       = ST_TIMEOUT;
      res_d.send_nak     = 1'b1;
      res_d.ack_position = pos_q;
      res_d.frame_length = cnt_q;
      restart            = 1'b1;
    end else if (phase_q == PH_PAYLOAD) begin
      if (!term) begin
        // bytes past the limit are dropped silently
        if (cnt_q < limit) begin
          crc_d            = crc_fold;
          has_res          = 1'b1;
          res_d.data_byte  = byte_v;
          res_d.byte_index = cnt_q[IdxW-1:0];
          cnt_d            = cnt_q + 1'b1;
        end
      end else begin
        type_d  = byte_v;
        crc_d   = crc_fold;
        phase_d = PH_TRAILER;
        got_d   = 2'd0;
        trl_d   = 32'h0;
        bad_d   = 1'b0;
      end
    end else begin
      bad_d = bad_q | term;
      if (mode) begin
        trl_d = trl_q | ({24'h0, byte_v} << {got_q, 3'b000});
      end else begin
        trl_d = {16'h0, trl_q[7:0], byte_v};
      end
      got_d = got_q + 1'b1;
      if (done) begin
        has_res            = 1'b1;
        res_d.kind         = 1'b1;
        res_d.frame_length = cnt_q;
        restart            = 1'b1;
        if (bad_d || trl_d != expect_crc) begin
          res_d.status       = ST_CRC_ERR;
          res_d.send_nak     = 1'b1;
          res_d.ack_position = pos_q;
        end else begin
          // position advances even when the type turns out invalid
          pos_d              = pos_q + {{(PosW-LenW){1'b0}}, cnt_q};
          res_d.ack_position = pos_d;
          case (type_q)
            TypeG: res_d.status = ST_CONT;
            TypeE: res_d.status = ST_END;
            TypeQ: begin
              res_d.status   = ST_CONT;
              res_d.send_ack = ack_en_q;
            end
            TypeW: begin
              res_d.status   = ST_END;
              res_d.send_ack = ack_en_q;
            end
            default: begin
              res_d.status   = ST_BAD_TYPE;
              res_d.send_nak = 1'b1;
            end
          endcase
        end
      end
    end

    if (restart) begin
      phase_d  = PH_PAYLOAD;
      mode32_d = crc32_mode_q;
      crc_d    = crc32_mode_q ? CrcInit32 : 32'h0;
      cnt_d    = '0;
      trl_d    = 32'h0;
      got_d    = 2'd0;
      bad_d    = 1'b0;
      fresh_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PAYLOAD;
      mode32_q     <= 1'b0;
      crc_q        <= 32'h0;
      cnt_q        <= '0;
      trl_q        <= 32'h0;
      got_q        <= 2'd0;
      bad_q        <= 1'b0;
      type_q       <= 8'h0;
      pos_q        <= '0;
      fresh_q      <= 1'b1;
      crc32_mode_q <= 1'b0;
      max_len_q    <= MaxLenReset;
      ack_en_q     <= 1'b1;
      res_valid_q  <= 1'b0;
    end else begin
      if (adv) begin
        phase_q     <= phase_d;
        mode32_q    <= mode32_d;
        crc_q       <= crc_d;
        cnt_q       <= cnt_d;
        trl_q       <= trl_d;
        got_q       <= got_d;
        bad_q       <= bad_d;
        type_q      <= type_d;
        pos_q       <= pos_d;
        fresh_q     <= fresh_d;
        res_valid_q <= has_res;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_i.en) begin
        unique case (cfg_i.index)
          CFG_CRC32_MODE:    crc32_mode_q <= cfg_i.data[0];
          CFG_MAX_LEN:       max_len_q    <= cfg_i.data[LenW-1:0];
          CFG_ACK_ENABLE:    ack_en_q     <= cfg_i.data[0];
          CFG_FILE_POS_INIT: pos_q        <= cfg_i.data[PosW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LimCap)
    else $error("stored count above buffer limit");

  a_restart_after_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && has_res && res_d.kind) |=> (cnt_q == '0 && phase_q == PH_PAYLOAD && fresh_q))
    else $error("subpacket state not restarted after status word");

  a_ack_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.send_ack) |->
      (res_q.kind && (res_q.status == ST_CONT || res_q.status == ST_END)))
    else $error("ack requested on a failed subpacket");

  a_nak_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind) |->
      (res_q.send_nak == (res_q.status == ST_CRC_ERR || res_q.status == ST_BAD_TYPE
                          || res_q.status == ST_TIMEOUT)))
    else $error("nak flag disagrees with status");

  a_crc16_trailer_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TRAILER && !mode32_q) |-> (got_q <= 2'd1))
    else $error("crc-16 trailer counter overran");

endmodule

FILE: bench/zmsr_checker.sv
// checker: follows symbol and register traffic, predicts each result word and compares it
module zmsr_checker #(
  parameter int BufDepth = zmsr_pkg::BufDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  zmsr_sym_if  sym,
  zmsr_res_if  res,
  zmsr_cfg_if  cfg,
  output int   fail_count_o,
  output int   waiting_o,
  output int   bytes_seen_o,
  output int   statuses_seen_o
);
  import zmsr_pkg::*;

  localparam int PrintCap = 100;

  typedef enum logic {RX_PAYLOAD, RX_TRAILER} rx_phase_e;

  // register copies
  logic        mode_reg;
  logic [10:0] limit_reg;
  logic        ack_reg;
  logic [31:0] ack_pos;

  // subpacket progress
  rx_phase_e   rx_phase;
  logic        mode_now;
  logic        fresh;
  logic [31:0] crc_acc;
  int unsigned n_stored;
  logic [31:0] trailer_val;
  int unsigned trailer_cnt;
  logic        trailer_marked;
  logic [7:0]  sub_type;

  res_t        outstanding[$];
  int          words_checked;

  function automatic logic [31:0] crc_add(logic wide, logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c;
    if (wide) begin
      v = v ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
        v = v[0] ? ((v >> 1) ^ 32'hedb8_8320) : (v >> 1);
      end
    end else begin
      v = {16'h0, v[15:0] ^ {b, 8'h00}};
      for (int k = 0; k < 8; k++) begin
        v = v[15] ? ({v[30:0], 1'b0} ^ 32'h0000_1021) : {v[30:0], 1'b0};
      end
      v[31:16] = 16'h0;
    end
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= PrintCap) begin
      $display("word %0d: %s got %0h, want %0h", words_checked, what, got, want);
    end
  endtask

  task automatic rearm();
    rx_phase       = RX_PAYLOAD;
    mode_now       = mode_reg;
    crc_acc        = mode_now ? CrcInit32 : 32'h0;
    n_stored       = 0;
    trailer_val    = 32'h0;
    trailer_cnt    = 0;
    trailer_marked = 1'b0;
    fresh          = 1'b1;
  endtask

  task automatic post_status(input status_e st, input logic ack, input logic nak);
    res_t e;
    e              = '0;
    e.kind         = 1'b1;
    e.status       = st;
    e.send_ack     = ack;
    e.send_nak     = nak;
    e.ack_position = ack_pos;
    e.frame_length = n_stored[10:0];
    outstanding.push_back(e);
  endtask

  task automatic follow_symbol(input logic [8:0] s, input logic to);
    res_t        e;
    int unsigned lim;
    logic [31:0] want;
    logic [7:0]  b;
    b = s[7:0];
    e = '0;
    // a timeout aborts from any phase and leaves the position alone
    if (to) begin
      post_status(ST_TIMEOUT, 1'b0, 1'b1);
      rearm();
      return;
    end
    if (fresh) begin
      mode_now = mode_reg;
      crc_acc  = mode_now ? CrcInit32 : 32'h0;
      fresh    = 1'b0;
    end
    if (rx_phase == RX_PAYLOAD) begin
      if (!s[8]) begin
        lim = (limit_reg < BufDepth) ? limit_reg : BufDepth;
        if (n_stored >= lim) return;
        crc_acc      = crc_add(mode_now, crc_acc, b);
        e.data_byte  = b;
        e.byte_index = n_stored[9:0];
        outstanding.push_back(e);
        n_stored++;
        return;
      end
      sub_type       = b;
      crc_acc        = crc_add(mode_now, crc_acc, b);
      rx_phase       = RX_TRAILER;
      trailer_val    = 32'h0;
      trailer_cnt    = 0;
      trailer_marked = 1'b0;
      return;
    end
    // trailer: crc-32 arrives lsb first, crc-16 msb first
    if (s[8]) trailer_marked = 1'b1;
    if (mode_now) begin
      trailer_val = trailer_val | ({24'h0, b} << (8 * (trailer_cnt % 4)));
    end else begin
      trailer_val = {16'h0, trailer_val[7:0], b};
    end
    trailer_cnt++;
    if (trailer_cnt < (mode_now ? 4 : 2)) return;
    want = mode_now ? ~crc_acc : crc_acc;
    if (trailer_marked || trailer_val != want) begin
      post_status(ST_CRC_ERR, 1'b0, 1'b1);
      rearm();
      return;
    end
    // good crc advances the position even for an unknown type
    ack_pos = ack_pos + n_stored;
    case (sub_type)
      TypeG:   post_status(ST_CONT, 1'b0, 1'b0);
      TypeE:   post_status(ST_END, 1'b0, 1'b0);
      TypeQ:   post_status(ST_CONT, ack_reg, 1'b0);
      TypeW:   post_status(ST_END, ack_reg, 1'b0);
      default: post_status(ST_BAD_TYPE, 1'b0, 1'b1);
    endcase
    rearm();
  endtask

  task automatic take_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_CRC32_MODE:    mode_reg  = data[0];
      CFG_MAX_LEN:       limit_reg = data[10:0];
      CFG_ACK_ENABLE:    ack_reg   = data[0];
      CFG_FILE_POS_INIT: ack_pos   = data;
      default: ;
    endcase
  endtask

  task automatic check_word();
    res_t want;
    if (res.kind) begin
      statuses_seen_o++;
    end else begin
      bytes_seen_o++;
    end
    if (outstanding.size() == 0) begin
      note_mismatch("word with nothing due, kind", 32'(res.kind), 32'h0);
      words_checked++;
      return;
    end
    want = outstanding.pop_front();
    if (res.kind != want.kind) begin
      note_mismatch("kind", 32'(res.kind), 32'(want.kind));
    end
    if (res.data_byte != want.data_byte) begin
      note_mismatch("data_byte", 32'(res.data_byte), 32'(want.data_byte));
    end
    if (res.byte_index != want.byte_index) begin
      note_mismatch("byte_index", 32'(res.byte_index), 32'(want.byte_index));
    end
    if (res.status != want.status) begin
      note_mismatch("status", 32'(res.status), 32'(want.status));
    end
    if (res.send_ack != want.send_ack) begin
      note_mismatch("send_ack", 32'(res.send_ack), 32'(want.send_ack));
    end
    if (res.send_nak != want.send_nak) begin
      note_mismatch("send_nak", 32'(res.send_nak), 32'(want.send_nak));
    end
    if (res.ack_position != want.ack_position) begin
      note_mismatch("ack_position", res.ack_position, want.ack_position);
    end
    if (res.frame_length != want.frame_length) begin
      note_mismatch("frame_length", 32'(res.frame_length), 32'(want.frame_length));
    end
    words_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_reg  = 1'b0;
      limit_reg = MaxLenReset;
      ack_reg   = 1'b1;
      ack_pos   = 32'h0;
      sub_type  = 8'h0;
      outstanding.delete();
      rearm();
    end else begin
      if (res.valid && res.ready) check_word();
      if (sym.valid && sym.ready) follow_symbol(sym.symbol, sym.timed_out);
      if (cfg.valid && cfg.ready) take_write(cfg.index, cfg.data);
    end
    waiting_o = outstanding.size();
  end

endmodule

FILE: bench/zmodem_data_subpacket_receiver_unit_test.sv
// testbench top: drives subpackets, noise and register settings into the receiver
module zmodem_data_subpacket_receiver_unit_test;
  import zmsr_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 4;
  localparam int RandomWords  = 300;
  localparam int PhaseWords   = 60;

  localparam logic [7:0] NullType = 8'h00;
  localparam logic [7:0] FullType = 8'hff;

  typedef enum int {CLEAN, CORRUPT_CRC, MARKED_TRAILER, ABORT_PAYLOAD, ABORT_TRAILER} flaw_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  bit   quiet;
  logic cur_mode;
  int   cur_limit;     // smaller of max_len and buffer depth
  int   words_sent;
  int   settings_run;

  int   fail_count;
  int   waiting;
  int   bytes_seen;
  int   statuses_seen;

  zmsr_sym_if sym_ch();
  zmsr_res_if res_ch();
  zmsr_cfg_if cfg_ch();

  zmodem_data_subpacket_receiver_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sym_i  (sym_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  zmsr_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sym             (sym_ch),
    .res             (res_ch),
    .cfg             (cfg_ch),
    .fail_count_o    (fail_count),
    .waiting_o       (waiting),
    .bytes_seen_o    (bytes_seen),
    .statuses_seen_o (statuses_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("run stopped at the cycle limit (%0d cycles)", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: mostly ready, short stalls and an occasional long one
  initial begin
    int hold;
    hold = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        res_ch.ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        res_ch.ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 8);
    if (r < 90) return $urandom_range(9, 40);
    if (cur_limit > 64) return $urandom_range(40, 64);
    return $urandom_range((cur_limit > 2) ? cur_limit - 2 : 0, cur_limit + 3);
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(0, 99) >= 70) return 8'($urandom);
    case ($urandom_range(0, 3))
      0:       return TypeE;
      1:       return TypeG;
      2:       return TypeQ;
      default: return TypeW;
    endcase
  endfunction

  function automatic flaw_e pick_flaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CLEAN;
    if (r < 78) return CORRUPT_CRC;
    if (r < 85) return MARKED_TRAILER;
    if (r < 93) return ABORT_PAYLOAD;
    return ABORT_TRAILER;
  endfunction

  function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
    return cur_mode ? crc32_fold(c, b) : {16'h0, crc16_fold(c[15:0], b)};
  endfunction

  task automatic put_word(input logic [8:0] s, input logic to);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sym_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sym_ch.valid     <= 1'b1;
    sym_ch.symbol    <= s;
    sym_ch.timed_out <= to;
    @(posedge clk_i);
    while (!sym_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // hold off until every due result is back, then let the pipeline empty
  task automatic settle();
    sym_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (waiting != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input cfg_idx_e idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_subpacket(input int len, input logic [7:0] kind_byte,
                                input flaw_e flaw, input bit extremes);
    logic [31:0] crc;
    logic [31:0] trailer;
    logic [7:0]  b;
    logic        marked;
    int          ntr;
    int          cut;
    int          mark_at;
    crc     = cur_mode ? CrcInit32 : 32'h0;
    ntr     = cur_mode ? 4 : 2;
    cut     = -1;
    if (flaw == ABORT_PAYLOAD) cut = $urandom_range(0, len);
    if (flaw == ABORT_TRAILER) cut = $urandom_range(0, ntr - 1);
    mark_at = $urandom_range(0, ntr - 1);
    for (int i = 0; i < len; i++) begin
      if (flaw == ABORT_PAYLOAD && i == cut) begin
        put_word(9'($urandom), 1'b1);
        return;
      end
      b = extremes ? ((i % 2 == 0) ? 8'h00 : 8'hff) : 8'($urandom);
      put_word({1'b0, b}, 1'b0);
      // bytes past the limit are dropped and stay out of the crc
      if (i < cur_limit) crc = crc_next(crc, b);
    end
    if (flaw == ABORT_PAYLOAD) begin
      put_word(9'($urandom), 1'b1);
      return;
    end
    put_word({1'b1, kind_byte}, 1'b0);
    crc = crc_next(crc, kind_byte);
    trailer = cur_mode ? ~crc : {16'h0, crc[15:0]};
    if (flaw == CORRUPT_CRC) trailer = trailer ^ (32'h1 << $urandom_range(0, 8 * ntr - 1));
    for (int j = 0; j < ntr; j++) begin
      if (flaw == ABORT_TRAILER && j == cut) begin
        put_word(9'($urandom), 1'b1);
        return;
      end
      b = cur_mode ? trailer[8*j +: 8] : trailer[8*(ntr-1-j) +: 8];
      marked = (flaw == MARKED_TRAILER && j == mark_at);
      put_word({marked, b}, 1'b0);
    end
  endtask

  // raw symbols, then a timeout to bring the receiver back to a clean start
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) put_word(9'($urandom), 1'b0);
    put_word(9'($urandom), 1'b1);
  endtask

  task automatic program_setting(input int k);
    logic        m;
    logic        a;
    logic        wp;
    logic [10:0] ml;
    logic [31:0] p;
    int          start;
    m  = 1'($urandom_range(0, 1));
    a  = 1'($urandom_range(0, 1));
    wp = 1'($urandom_range(0, 1));
    p  = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      ml = $urandom_range(0, 1) ? 11'd0 : 11'd1024;
    end else begin
      ml = 11'($urandom_range(0, 40));
    end
    case (k)
      0: begin m = 1'b1; ml = 11'd1024; a = 1'b1; p = 32'hffff_fff0; wp = 1'b1; end
      1: begin m = 1'b0; ml = 11'd0;    a = 1'b0; wp = 1'b1; end
      2: begin m = 1'b1; ml = 11'd1;    a = 1'b1; wp = 1'b0; end
      3: begin m = 1'b0; ml = 11'd17;   a = 1'b1; p = 32'hffff_ffff; wp = 1'b1; end
      4: begin m = 1'b1; ml = 11'd6;    a = 1'b0; wp = 1'b0; end
      default: ;
    endcase
    settle();
    start = $urandom_range(0, 3);
    for (int j = 0; j < 4; j++) begin
      case ((start + j) % 4)
        0:       reg_write(CFG_CRC32_MODE, {31'h0, m});
        1:       reg_write(CFG_MAX_LEN, {21'h0, ml});
        2:       reg_write(CFG_ACK_ENABLE, {31'h0, a});
        default: if (wp) reg_write(CFG_FILE_POS_INIT, p);
      endcase
    end
    cfg_ch.valid <= 1'b0;
    cur_mode  = m;
    cur_limit = (ml < BufDepthDef) ? ml : BufDepthDef;
    settings_run++;
  endtask

  initial begin
    int phase_end;
    sym_ch.valid     = 1'b0;
    sym_ch.symbol    = '0;
    sym_ch.timed_out = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    quiet            = 1'b0;
    cur_mode         = 1'b0;
    cur_limit        = BufDepthDef;
    words_sent       = 0;
    settings_run     = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, crc-16
    send_subpacket(2, TypeG, CLEAN, 1'b1);
    send_subpacket(0, TypeE, CLEAN, 1'b0);
    send_subpacket(1, TypeQ, CORRUPT_CRC, 1'b1);
    send_subpacket(1, TypeW, MARKED_TRAILER, 1'b1);
    send_subpacket(0, NullType, CLEAN, 1'b0);
    send_subpacket(0, FullType, CLEAN, 1'b0);
    send_subpacket(1, TypeG, ABORT_PAYLOAD, 1'b1);
    send_subpacket(0, TypeE, ABORT_TRAILER, 1'b0);

    // random subpackets under a run of register settings
    for (int k = 0; words_sent < RandomWords; k++) begin
      program_setting(k);
      quiet = ($urandom_range(0, 3) == 0);
      phase_end = words_sent + PhaseWords;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 99) < 8) begin
          send_noise();
        end else begin
          send_subpacket(pick_len(), pick_type(), pick_flaw(), 1'b0);
        end
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    // one subpacket that fills the buffer and runs past it
    program_setting(0);
    quiet = 1'b0;
    send_subpacket(BufDepthDef + 6, TypeW, CLEAN, 1'b0);

    settle();
    $display("sent %0d symbol words under %0d register settings, both crc modes",
             words_sent, settings_run);
    $display("checked %0d stored bytes and %0d subpacket status words",
             bytes_seen, statuses_seen);
    if (fail_count == 0 && waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: zmodem_data_subpacket_receiver_unit.f
rtl/zmsr_pkg.sv
rtl/zmsr_if.sv
rtl/zmsr_in_stage.sv
rtl/zmsr_core.sv
rtl/zmodem_data_subpacket_receiver_unit.sv
bench/zmsr_checker.sv
bench/zmodem_data_subpacket_receiver_unit_test.sv
